/* hw/rtl/ordered_array_list_engine_assert.svh */
// Assertion macros shared by the ordered array list engine RTL.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef ORDERED_ARRAY_LIST_ENGINE_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication: the consequent must hold whenever the antecedent does.
`define OALE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("oale: same-cycle check failed");

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define OALE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("oale: next-cycle check failed");

`endif

/* hw/rtl/oale_pkg.sv */
// Package for the ordered array list engine: sizes, operation codes and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none

package oale_pkg;

    // List storage depth and derived widths.
    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed field widths of the item interfaces.
    localparam int MODE_W  = 3;
    localparam int IDX_W   = 5;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 5;
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    // Operation codes carried by the mode field.
    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_DELETE = 3'd2,
        MODE_SEARCH = 3'd3,
        MODE_SWAP   = 3'd4
    } mode_t;

    // Read address sources for the entry memory.
    typedef enum logic [1:0] {
        RA_ZERO    = 2'd0,
        RA_POS     = 2'd1,
        RA_PTR_DEC = 2'd2,
        RA_PTR_INC = 2'd3
    } rd_sel_t;

    // Write address sources for the entry memory.
    typedef enum logic [1:0] {
        WA_ZERO  = 2'd0,
        WA_COUNT = 2'd1,
        WA_PTR   = 2'd2
    } wa_sel_t;

    // Write data sources for the entry memory.
    typedef enum logic {
        WD_VALUE = 1'b0,
        WD_RDATA = 1'b1
    } wd_sel_t;

    // Pointer register updates.
    typedef enum logic [2:0] {
        PTR_HOLD  = 3'd0,
        PTR_COUNT = 3'd1,
        PTR_POS   = 3'd2,
        PTR_ZERO  = 3'd3,
        PTR_DEC   = 3'd4,
        PTR_INC   = 3'd5
    } ptr_op_t;

    // Entry count updates.
    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } cnt_op_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic    load_op;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wa_sel_t wa_sel;
        wd_sel_t wd_sel;
        ptr_op_t ptr_op;
        cnt_op_t cnt_op;
        logic    set_ok;
        logic    set_removed;
        logic    set_found;
        logic    publish;
    } oale_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        mode_t mode;
        logic  can_add;
        logic  ins_ok;
        logic  del_ok;
        logic  list_empty;
        logic  ptr_gt_pos;
        logic  ptr_more;
        logic  match;
        logic  out_free;
    } oale_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/oale_regs.sv */
// APB-style configuration register block holding the list capacity.
// Depends on oale_pkg for the port widths and register index.
`default_nettype none

module oale_regs
    import oale_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output logic      [CAP_W-1:0]   capacity
);

    logic             reg_sel;
    logic             wr_hit;
    logic [CAP_W-1:0] capacity_reg;

    // Registers sit on 4-byte boundaries; bit 2 picks the register.
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;
    assign wr_hit  = psel && penable && pwrite && pready;

    // Capacity register write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
        end else if (wr_hit && (reg_sel == REG_CAPACITY)) begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    // Read mux; addresses beyond the register list read as zero.
    always_comb begin
        unique case (reg_sel)
            REG_CAPACITY: prdata = PDATA_W'(capacity_reg);
            default:      prdata = '0;
        endcase
    end

    assign capacity = capacity_reg;

endmodule

`default_nettype wire

/* hw/rtl/oale_dp.sv */
// Datapath of the ordered array list engine: entry memory, pointer, count,
// latched operation, result accumulation and the output register.
// Depends on oale_pkg and the assertion macro header.
`default_nettype none

`include "ordered_array_list_engine_assert.svh"

module oale_dp
    import oale_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire oale_cmd_t               cmd,
    output oale_sts_t                    sts,
    input  wire logic [MODE_W-1:0]       s_mode,
    input  wire logic [IDX_W-1:0]        s_index,
    input  wire logic signed [VAL_W-1:0] s_value,
    input  wire logic [CAP_W-1:0]        capacity,
    input  wire logic                    m_ready,
    output logic                         m_valid,
    output logic                         m_ok,
    output logic signed [VAL_W-1:0]      m_removed_value,
    output logic signed [POS_W-1:0]      m_found_position,
    output logic [POS_W-1:0]             m_count_after
);

    // Entry memory with one write and one registered read port.
    logic [VAL_W-1:0]  mem [DEPTH];
    logic [VAL_W-1:0]  rd_data_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  ptr_reg;
    logic [CNT_W-1:0]  ptr_next;

    logic [MODE_W-1:0] op_mode_reg;
    logic [IDX_W-1:0]  op_index_reg;
    logic [VAL_W-1:0]  op_value_reg;

    logic              res_ok_reg;
    logic [VAL_W-1:0]  res_removed_reg;
    logic [POS_W-1:0]  res_found_reg;

    logic              m_valid_reg;
    logic              m_ok_reg;
    logic [VAL_W-1:0]  m_removed_reg;
    logic [POS_W-1:0]  m_found_reg;
    logic [POS_W-1:0]  m_count_reg;

    logic [CNT_W-1:0]  rd_full;
    logic [CNT_W-1:0]  wr_full;
    logic [VAL_W-1:0]  wr_data;
    logic [CMP_W-1:0]  count_ext;
    logic [CMP_W-1:0]  ptr_ext;
    logic [CMP_W-1:0]  index_ext;
    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  limit_ext;

    // Widened copies for comparisons.
    assign count_ext = CMP_W'(count_reg);
    assign ptr_ext   = CMP_W'(ptr_reg);
    assign index_ext = CMP_W'(op_index_reg);
    assign cap_ext   = CMP_W'(capacity);
    assign limit_ext = (cap_ext < CMP_W'(DEPTH)) ? cap_ext : CMP_W'(DEPTH);

    // Status toward the controller.
    always_comb begin
        sts.mode       = mode_t'(op_mode_reg);
        sts.can_add    = count_ext < limit_ext;
        sts.ins_ok     = index_ext <= count_ext;
        sts.del_ok     = index_ext < count_ext;
        sts.list_empty = count_reg == '0;
        sts.ptr_gt_pos = ptr_ext > index_ext;
        sts.ptr_more   = (ptr_ext + CMP_W'(1)) < count_ext;
        sts.match      = rd_data_reg == op_value_reg;
        sts.out_free   = !m_valid_reg || m_ready;
    end

    // Memory address and data selection.
    always_comb begin
        case (cmd.rd_sel)
            RA_POS:     rd_full = CNT_W'(op_index_reg);
            RA_PTR_DEC: rd_full = ptr_reg - CNT_W'(1);
            RA_PTR_INC: rd_full = ptr_reg + CNT_W'(1);
            default:    rd_full = '0;
        endcase
        case (cmd.wa_sel)
            WA_COUNT: wr_full = count_reg;
            WA_PTR:   wr_full = ptr_reg;
            default:  wr_full = '0;
        endcase
        case (cmd.wd_sel)
            WD_RDATA: wr_data = rd_data_reg;
            default:  wr_data = op_value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_full[ADDR_W-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_full[ADDR_W-1:0]];
        end
    end

    // Pointer and count updates.
    always_comb begin
        case (cmd.ptr_op)
            PTR_COUNT: ptr_next = count_reg;
            PTR_POS:   ptr_next = CNT_W'(op_index_reg);
            PTR_ZERO:  ptr_next = '0;
            PTR_DEC:   ptr_next = ptr_reg - CNT_W'(1);
            PTR_INC:   ptr_next = ptr_reg + CNT_W'(1);
            default:   ptr_next = ptr_reg;
        endcase
        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CNT_W'(1);
            CNT_DEC: count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Operation latch and result accumulation.
    always_ff @(posedge aclk) begin
        if (cmd.load_op) begin
            op_mode_reg     <= s_mode;
            op_index_reg    <= s_index;
            op_value_reg    <= s_value;
            res_ok_reg      <= 1'b0;
            res_removed_reg <= '0;
            res_found_reg   <= '1;
        end else begin
            if (cmd.set_ok) begin
                res_ok_reg <= 1'b1;
            end
            if (cmd.set_removed) begin
                res_removed_reg <= rd_data_reg;
            end
            if (cmd.set_found) begin
                res_found_reg <= POS_W'(ptr_reg);
            end
        end
    end

    // Output register; the result is held until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            m_ok_reg      <= res_ok_reg;
            m_removed_reg <= res_removed_reg;
            m_found_reg   <= res_found_reg;
            m_count_reg   <= POS_W'(count_reg);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_ok             = m_ok_reg;
    assign m_removed_value  = m_removed_reg;
    assign m_found_position = m_found_reg;
    assign m_count_after    = m_count_reg;

    // The count never passes the storage depth.
    `OALE_ASSERT_NOW(a_count_bound, 1'b1, CMP_W'(count_reg) <= CMP_W'(DEPTH))
    // Writes land only inside the list or at its tail.
    `OALE_ASSERT_NOW(a_write_bound, cmd.wr_en, wr_full <= count_reg)
    // A result is loaded only when the output register is free.
    `OALE_ASSERT_NOW(a_publish_free, cmd.publish, !m_valid_reg || m_ready)
    // Growth only when room is left; shrink only after a successful removal.
    `OALE_ASSERT_NOW(a_grow_room, cmd.cnt_op == CNT_INC, sts.can_add)
    `OALE_ASSERT_NOW(a_shrink_ok, cmd.cnt_op == CNT_DEC, res_ok_reg)
    // A freshly latched item starts with a not-found, refused result.
    `OALE_ASSERT_NEXT(a_load_clear, cmd.load_op, !res_ok_reg && (res_found_reg == '1))

endmodule

`default_nettype wire

/* hw/rtl/oale_ctrl.sv */
// Controller state machine of the ordered array list engine: sequences the
// memory reads, shifts and result updates. Depends on oale_pkg.
`default_nettype none

module oale_ctrl
    import oale_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire oale_sts_t sts,
    output oale_cmd_t      cmd
);

    typedef enum logic [10:0] {
        S_IDLE       = 11'b000_0000_0001,
        S_DISPATCH   = 11'b000_0000_0010,
        S_INS_CHK    = 11'b000_0000_0100,
        S_INS_WR     = 11'b000_0000_1000,
        S_DEL_RD     = 11'b000_0001_0000,
        S_DEL_CHK    = 11'b000_0010_0000,
        S_DEL_WR     = 11'b000_0100_0000,
        S_SRCH_CMP   = 11'b000_1000_0000,
        S_SWAP_WR    = 11'b001_0000_0000,
        S_SWAP_FRONT = 11'b010_0000_0000,
        S_DONE       = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_op = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end

            // First step of each operation, with its bound checks.
            S_DISPATCH: begin
                state_next = S_DONE;
                case (sts.mode) inside
                    MODE_APPEND: begin
                        if (sts.can_add) begin
                            cmd.wr_en  = 1'b1;
                            cmd.wa_sel = WA_COUNT;
                            cmd.wd_sel = WD_VALUE;
                            cmd.cnt_op = CNT_INC;
                            cmd.set_ok = 1'b1;
                        end
                    end
                    MODE_INSERT: begin
                        if (sts.ins_ok && sts.can_add) begin
                            cmd.ptr_op = PTR_COUNT;
                            state_next = S_INS_CHK;
                        end
                    end
                    MODE_DELETE: begin
                        if (sts.del_ok) begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RA_POS;
                            cmd.ptr_op = PTR_POS;
                            state_next = S_DEL_RD;
                        end
                    end
                    MODE_SEARCH, MODE_SWAP: begin
                        if (!sts.list_empty) begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RA_ZERO;
                            cmd.ptr_op = PTR_ZERO;
                            state_next = S_SRCH_CMP;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // Insert: move entries up from the tail, then place the word.
            S_INS_CHK: begin
                if (sts.ptr_gt_pos) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_PTR_DEC;
                    state_next = S_INS_WR;
                end else begin
                    cmd.wr_en  = 1'b1;
                    cmd.wa_sel = WA_PTR;
                    cmd.wd_sel = WD_VALUE;
                    cmd.cnt_op = CNT_INC;
                    cmd.set_ok = 1'b1;
                    state_next = S_DONE;
                end
            end

            S_INS_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_PTR;
                cmd.wd_sel = WD_RDATA;
                cmd.ptr_op = PTR_DEC;
                state_next = S_INS_CHK;
            end

            // Delete: capture the removed word, then move entries down.
            S_DEL_RD: begin
                cmd.set_removed = 1'b1;
                cmd.set_ok      = 1'b1;
                state_next      = S_DEL_CHK;
            end

            S_DEL_CHK: begin
                if (sts.ptr_more) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_PTR_INC;
                    state_next = S_DEL_WR;
                end else begin
                    cmd.cnt_op = CNT_DEC;
                    state_next = S_DONE;
                end
            end

            S_DEL_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_PTR;
                cmd.wd_sel = WD_RDATA;
                cmd.ptr_op = PTR_INC;
                state_next = S_DEL_CHK;
            end

            // Search: compare one entry per cycle from the front.
            S_SRCH_CMP: begin
                if (sts.match) begin
                    cmd.set_found = 1'b1;
                    cmd.set_ok    = 1'b1;
                    if (sts.mode == MODE_SWAP) begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RA_ZERO;
                        state_next = S_SWAP_WR;
                    end else begin
                        state_next = S_DONE;
                    end
                end else if (sts.ptr_more) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_PTR_INC;
                    cmd.ptr_op = PTR_INC;
                end else begin
                    state_next = S_DONE;
                end
            end

            // Swap: the old front goes to the match, the key goes to the front.
            S_SWAP_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_PTR;
                cmd.wd_sel = WD_RDATA;
                state_next = S_SWAP_FRONT;
            end

            S_SWAP_FRONT: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_ZERO;
                cmd.wd_sel = WD_VALUE;
                state_next = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/ordered_array_list_engine.sv */
// Top level of the ordered array list engine: joins the configuration
// registers, the controller and the datapath. Depends on oale_pkg and the
// oale_regs, oale_ctrl and oale_dp modules.
//
// Usage: the input channel (s_valid/s_ready) carries one item per operation:
// mode, index and value. The result channel (m_valid/m_ready) returns exactly
// one item per input: ok, removed_value, found_position and count_after.
// The capacity register is written over the APB-style port; the user must do
// so only while idle, as the block does not enforce it. Items are handled one
// at a time by a controller stepping an entry memory with one write and one
// registered read port. Append and every refused item go straight to the
// result; insert moves entries up from the tail, then places the word; delete
// captures the removed word, then moves entries down; search compares from the
// front until it hits or runs out; swap then trades the match with the front.
// The result sits in an output register; a new item is accepted while it
// waits, and a stalled receiver only holds the engine at the end of the
// following item until the register frees up.
// Reset empties the list (count zero) and sets capacity to 16; no clearing
// pass runs, and the block accepts items in the first cycle after reset.
`default_nettype none

module ordered_array_list_engine
    import oale_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [MODE_W-1:0]       s_mode,
    input  wire logic [IDX_W-1:0]        s_index,
    input  wire logic signed [VAL_W-1:0] s_value,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic                         m_ok,
    output logic signed [VAL_W-1:0]      m_removed_value,
    output logic signed [POS_W-1:0]      m_found_position,
    output logic [POS_W-1:0]             m_count_after,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [PADDR_W-1:0]      paddr,
    input  wire logic [PDATA_W-1:0]      pwdata,
    output logic [PDATA_W-1:0]           prdata,
    output logic                         pready
);

    oale_cmd_t        cmd;
    oale_sts_t        sts;
    logic [CAP_W-1:0] capacity;

    oale_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    oale_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    oale_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_mode           (s_mode),
        .s_index          (s_index),
        .s_value          (s_value),
        .capacity         (capacity),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_ok             (m_ok),
        .m_removed_value  (m_removed_value),
        .m_found_position (m_found_position),
        .m_count_after    (m_count_after)
    );

endmodule

`default_nettype wire

/* sim/oale_checker.sv */
`timescale 1ns / 100ps
// Checker for the ordered array list engine: watches the item, result and configuration
// ports, keeps its own copy of the list and the capacity, and compares every result.
// Depends on oale_pkg only; it drives nothing on the block.
module oale_checker
    import oale_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [MODE_W-1:0]       s_mode,
    input  logic [IDX_W-1:0]        s_index,
    input  logic signed [VAL_W-1:0] s_value,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic                    m_ok,
    input  logic signed [VAL_W-1:0] m_removed_value,
    input  logic signed [POS_W-1:0] m_found_position,
    input  logic [POS_W-1:0]        m_count_after,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [PDATA_W-1:0]      pwdata,
    input  logic [PDATA_W-1:0]      prdata,
    input  logic                    pready,
    output int                      mismatch_count,
    output int                      results_owed,
    output int                      results_checked,
    output int                      key_hits
);

    localparam logic [PADDR_W-1:0] CAPACITY_ADDR = PADDR_W'(4 * REG_CAPACITY);
    localparam logic [POS_W-1:0]   NO_MATCH      = '1;
    localparam int                 REPORT_LIMIT  = 10;

    // One result item as the block presents it.
    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] removed;
        logic [POS_W-1:0] found;
        logic [POS_W-1:0] count;
    } list_result_t;

    // Shadow copy of the list, its length and the capacity register.
    logic [VAL_W-1:0] list_words [DEPTH];
    int               list_len;
    logic [CAP_W-1:0] capacity_q;
    list_result_t     owed_results [$];
    int               errors;
    int               checked;
    int               hits;

    initial begin
        mismatch_count  = 0;
        results_owed    = 0;
        results_checked = 0;
        key_hits        = 0;
        errors          = 0;
        checked         = 0;
        hits            = 0;
        list_len        = 0;
        capacity_q      = CAPACITY_RESET;
    end

    // Applies one operation to the shadow list and returns the result it must give.
    function automatic list_result_t apply_list_op(input logic [MODE_W-1:0] op,
                                                   input logic [IDX_W-1:0]  pos,
                                                   input logic [VAL_W-1:0]  word);
        list_result_t res;
        int           room;
        int           i;
        logic [VAL_W-1:0] front;
        logic         hit;
        res.ok      = 1'b0;
        res.removed = '0;
        res.found   = NO_MATCH;
        // The limit applied is the capacity, saturated at the storage depth.
        room = (int'(capacity_q) < DEPTH) ? int'(capacity_q) : DEPTH;
        hit  = 1'b0;
        case (op) inside
            MODE_APPEND: begin
                if (list_len < room) begin
                    list_words[list_len] = word;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            MODE_INSERT: begin
                if (int'(pos) <= list_len && list_len < room) begin
                    for (i = list_len; i > int'(pos); i--) begin
                        list_words[i] = list_words[i-1];
                    end
                    list_words[pos] = word;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            MODE_DELETE: begin
                if (int'(pos) < list_len) begin
                    res.removed = list_words[pos];
                    for (i = int'(pos); i + 1 < list_len; i++) begin
                        list_words[i] = list_words[i+1];
                    end
                    list_len--;
                    res.ok = 1'b1;
                end
            end
            MODE_SEARCH, MODE_SWAP: begin
                // First match wins; the swap variant trades it with the front entry.
                for (i = 0; i < list_len; i++) begin
                    if (!hit && list_words[i] == word) begin
                        hit       = 1'b1;
                        res.found = POS_W'(i);
                        res.ok    = 1'b1;
                        if (op == MODE_SWAP) begin
                            front         = list_words[0];
                            list_words[0] = list_words[i];
                            list_words[i] = front;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.count = POS_W'(list_len);
        return res;
    endfunction

    task automatic log_failure(input string what);
        errors++;
        if (errors <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Results are checked before the item of the same cycle is predicted, since a
    // result can never belong to an item accepted at the same edge.
    always @(posedge aclk) begin
        list_result_t want;
        list_result_t got;
        if (!aresetn) begin
            list_len   = 0;
            capacity_q = CAPACITY_RESET;
            owed_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                checked++;
                got = {m_ok, m_removed_value, m_found_position, m_count_after};
                if (owed_results.size() == 0) begin
                    log_failure($sformatf("result %0d arrived with no item waiting for it",
                                          checked));
                end else begin
                    want = owed_results.pop_front();
                    if (got !== want) begin
                        log_failure($sformatf({"result %0d: expected ok %0d removed %0d ",
                            "found %0d count %0d, got ok %0d removed %0d found %0d count %0d"},
                            checked, want.ok, $signed(want.removed), $signed(want.found),
                            want.count, got.ok, $signed(got.removed), $signed(got.found),
                            got.count));
                    end
                end
            end

            if (s_valid && s_ready) begin
                want = apply_list_op(s_mode, s_index, s_value);
                if (want.found != NO_MATCH) begin
                    hits++;
                end
                owed_results.push_back(want);
            end

            // Register writes update the shadow capacity; reads must return it.
            if (psel && penable && pready) begin
                if (pwrite && paddr == CAPACITY_ADDR) begin
                    capacity_q = pwdata[CAP_W-1:0];
                end else if (!pwrite && paddr == CAPACITY_ADDR &&
                             prdata !== PDATA_W'(capacity_q)) begin
                    log_failure($sformatf("capacity read back %0d, expected %0d",
                                          prdata, capacity_q));
                end
            end
        end
        mismatch_count  <= errors;
        results_owed    <= owed_results.size();
        results_checked <= checked;
        key_hits        <= hits;
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Top of the ordered array list engine testbench: clock, reset, item and register
// stimulus, and the verdict. Depends on oale_pkg, the engine RTL and oale_checker.
module tb_top;
    import oale_pkg::*;

    localparam logic [PADDR_W-1:0] CAPACITY_ADDR  = PADDR_W'(4 * REG_CAPACITY);
    localparam logic [MODE_W-1:0]  MODE_SPARE5    = 3'd5;
    localparam logic [MODE_W-1:0]  MODE_SPARE6    = 3'd6;
    localparam logic [MODE_W-1:0]  MODE_SPARE7    = 3'd7;
    localparam int                 NUM_PHASES     = 8;
    localparam int                 PHASE_ITEMS    = 172;
    localparam int                 HOLDOFF_CYCLES = 300;
    localparam int                 STALL_LIMIT    = 4000;
    localparam int                 DRAIN_CYCLES   = 40;

    logic                    aclk            = 1'b0;
    logic                    aresetn         = 1'b0;
    logic                    s_valid         = 1'b0;
    logic                    s_ready;
    logic [MODE_W-1:0]       s_mode          = '0;
    logic [IDX_W-1:0]        s_index         = '0;
    logic signed [VAL_W-1:0] s_value         = '0;
    logic                    m_valid;
    logic                    m_ready         = 1'b0;
    logic                    m_ok;
    logic signed [VAL_W-1:0] m_removed_value;
    logic signed [POS_W-1:0] m_found_position;
    logic [POS_W-1:0]        m_count_after;
    logic                    psel            = 1'b0;
    logic                    penable         = 1'b0;
    logic                    pwrite          = 1'b0;
    logic [PADDR_W-1:0]      paddr           = '0;
    logic [PDATA_W-1:0]      pwdata          = '0;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int holdoff_req  = 0;
    int holdoff_seen = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int items_sent   = 0;
    int settings_used = 0;
    int mismatch_count;
    int results_owed;
    int results_checked;
    int key_hits;

    always #2 aclk = ~aclk;

    ordered_array_list_engine u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_index          (s_index),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ok             (m_ok),
        .m_removed_value  (m_removed_value),
        .m_found_position (m_found_position),
        .m_count_after    (m_count_after),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    oale_checker u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_index          (s_index),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ok             (m_ok),
        .m_removed_value  (m_removed_value),
        .m_found_position (m_found_position),
        .m_count_after    (m_count_after),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .mismatch_count   (mismatch_count),
        .results_owed     (results_owed),
        .results_checked  (results_checked),
        .key_hits         (key_hits)
    );

    // Result receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready      <= 1'b0;
            hold_left    <= 0;
            holdoff_seen <= 0;
        end else if (holdoff_seen != holdoff_req) begin
            m_ready      <= 1'b0;
            hold_left    <= HOLDOFF_CYCLES;
            holdoff_seen <= holdoff_req;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Watchdog: ends the run when nothing moves on any port for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding.",
                     STALL_LIMIT, results_owed);
            $display("[ordered_array_list_engine] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one item, after a random gap, and returns once it is accepted.
    task automatic send_item(input logic [MODE_W-1:0] op, input logic [IDX_W-1:0] pos,
                             input logic [VAL_W-1:0] word);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= op;
        s_index <= pos;
        s_value <= word;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Waits until every result is back, then writes the capacity and reads it back.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= PDATA_W'(cap);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    // Mostly valid operations at low positions with values from a small pool, so
    // searches hit and inserts and deletes land inside the list; the rest is noise.
    task automatic send_random_item();
        int               roll;
        logic [MODE_W-1:0] op;
        logic [IDX_W-1:0]  pos;
        logic [VAL_W-1:0]  word;
        roll = $urandom_range(0, 99);
        if (roll < 24) begin
            op = MODE_APPEND;
        end else if (roll < 44) begin
            op = MODE_INSERT;
        end else if (roll < 70) begin
            op = MODE_DELETE;
        end else if (roll < 84) begin
            op = MODE_SEARCH;
        end else if (roll < 97) begin
            op = MODE_SWAP;
        end else begin
            op = MODE_W'($urandom_range(MODE_SPARE5, MODE_SPARE7));
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            pos = IDX_W'($urandom_range(0, 3));
        end else if (roll < 92) begin
            pos = IDX_W'($urandom_range(0, DEPTH));
        end else begin
            pos = IDX_W'($urandom);
        end
        if ($urandom_range(0, 99) < 70) begin
            case ($urandom_range(0, 7))
                0: word = 32'h8000_0000;
                1: word = 32'h7fff_ffff;
                2: word = 32'hffff_ffff;
                3: word = 32'h0000_0000;
                4: word = 32'h0000_0001;
                5: word = 32'h0000_0002;
                6: word = 32'h0000_0003;
                default: word = 32'h0000_0064;
            endcase
        end else begin
            word = $urandom;
        end
        send_item(op, pos, word);
    endtask

    initial begin
        int               phase;
        int               n;
        logic [CAP_W-1:0] cap;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: empty list, extremes of value and index, every mode.
        send_item(MODE_SEARCH, 5'd0, 32'h0000_0000);
        send_item(MODE_SWAP,   5'd0, 32'hffff_ffff);
        send_item(MODE_DELETE, 5'd0, 32'h0000_0000);
        send_item(MODE_INSERT, 5'd1, 32'h0000_0005);
        send_item(MODE_INSERT, 5'd0, 32'h8000_0000);
        send_item(MODE_APPEND, 5'd0, 32'h7fff_ffff);
        send_item(MODE_APPEND, 5'd0, 32'hffff_ffff);
        send_item(MODE_INSERT, 5'd3, 32'h0000_0000);
        send_item(MODE_INSERT, 5'd1, 32'h0000_0005);
        send_item(MODE_SEARCH, 5'd0, 32'hffff_ffff);
        send_item(MODE_SWAP,   5'd0, 32'h8000_0000);
        send_item(MODE_SWAP,   5'd0, 32'h0000_0000);
        send_item(MODE_SEARCH, 5'd0, 32'h0000_04d2);
        send_item(MODE_DELETE, 5'd31, 32'h0000_0000);
        send_item(MODE_DELETE, 5'd5, 32'h0000_0000);
        send_item(MODE_DELETE, 5'd4, 32'h0000_0000);
        send_item(MODE_DELETE, 5'd0, 32'h0000_0000);
        send_item(MODE_SPARE5, 5'd31, 32'hffff_ffff);
        send_item(MODE_SPARE6, 5'd0, 32'h0000_0000);
        send_item(MODE_SPARE7, 5'd16, 32'h5a5a_a5a5);
        send_item(MODE_INSERT, 5'd16, 32'h0000_0001);

        // Capacity dropped below the current count: adds are refused until it falls.
        write_capacity(5'd2);
        send_item(MODE_APPEND, 5'd0, 32'h0000_0009);
        send_item(MODE_INSERT, 5'd0, 32'h0000_0009);
        send_item(MODE_DELETE, 5'd0, 32'h0000_0000);
        send_item(MODE_APPEND, 5'd0, 32'h0000_0009);

        // Random part: one capacity and one idling pattern per phase.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: cap = 5'd16;
                1: cap = 5'd31;
                2: cap = 5'd4;
                3: cap = 5'd0;
                4: cap = 5'd1;
                5: cap = 5'd17;
                6: cap = 5'd9;
                default: cap = 5'd16;
            endcase
            write_capacity(cap);
            case (phase % 4)
                0: begin
                    tx_idle_pct   = 0;
                    rx_stall_pct <= 0;
                end
                1: begin
                    tx_idle_pct   = 78;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_idle_pct   = 0;
                    rx_stall_pct <= 78;
                end
                default: begin
                    tx_idle_pct   = 11;
                    rx_stall_pct <= 11;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Long receiver hold-off while items keep coming, to fill the engine.
                if (phase == 0 && n == 40) begin
                    holdoff_req <= holdoff_req + 1;
                end
                send_random_item();
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run: %0d items under %0d capacity writes, %0d results checked.",
                 items_sent, settings_used, results_checked);
        $display("Searches that found their key: %0d; mismatches: %0d.",
                 key_hits, mismatch_count);
        if (mismatch_count == 0 && results_owed == 0) begin
            $display("[ordered_array_list_engine] OK");
        end else begin
            $display("[ordered_array_list_engine] ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/oale_pkg.sv
hw/rtl/oale_regs.sv
hw/rtl/oale_dp.sv
hw/rtl/oale_ctrl.sv
hw/rtl/ordered_array_list_engine.sv
sim/oale_checker.sv
sim/tb_top.sv
